FILE: hw/rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and codes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned WIDE_BITS  = 64;
  localparam int unsigned MUL_BITS   = 33;
  localparam int unsigned CNT_BITS   = 7;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERODEN = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_OVF     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_GCD_START,
    S_GCD_RUN,
    S_DIVN_START,
    S_DIVN_RUN,
    S_DIVD_START,
    S_DIVD_RUN,
    S_FINAL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic comb;
    logic gcd_init;
    logic divn_init;
    logic divd_init;
    logic step;
    logic fin;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic early_err;
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

FILE: hw/rtl/rau_if.sv
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels for operand and result words.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;
  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  status;
  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

FILE: hw/rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: checks, products, combining step, Euclid loop, two reducing divisions, output.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);
  import rau_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:       if (in_valid) state_nxt = S_CHECK;
      S_CHECK:      state_nxt = sts.early_err ? S_OUT : S_MUL1;
      S_MUL1:       state_nxt = S_MUL2;
      S_MUL2:       state_nxt = S_COMB;
      S_COMB:       state_nxt = S_GCD_START;
      S_GCD_START:  state_nxt = sts.num_zero ? S_FINAL : S_GCD_RUN;
      S_GCD_RUN:    if (sts.gcd_done) state_nxt = S_DIVN_START;
      S_DIVN_START: state_nxt = S_DIVN_RUN;
      S_DIVN_RUN:   if (sts.div_done) state_nxt = S_DIVD_START;
      S_DIVD_START: state_nxt = S_DIVD_RUN;
      S_DIVD_RUN:   if (sts.div_done) state_nxt = S_FINAL;
      S_FINAL:      state_nxt = S_OUT;
      S_OUT:        if (out_ready) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE:       begin in_ready = 1'b1; cmd.load = in_valid; end
      S_MUL1:       cmd.mul1 = 1'b1;
      S_MUL2:       cmd.mul2 = 1'b1;
      S_COMB:       cmd.comb = 1'b1;
      S_GCD_START:  cmd.gcd_init = 1'b1;
      S_GCD_RUN:    cmd.step = 1'b1;
      S_DIVN_START: cmd.divn_init = 1'b1;
      S_DIVN_RUN:   cmd.step = 1'b1;
      S_DIVD_START: cmd.divd_init = 1'b1;
      S_DIVD_RUN:   cmd.step = 1'b1;
      S_FINAL:      cmd.fin = 1'b1;
      S_OUT:        cmd.out_valid = 1'b1;
      default:      cmd = '0;
    endcase
  end
endmodule

FILE: hw/rtl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, two 33x33 multipliers, 64-bit Euclid by
// shift-subtract remainder, restoring divider, result range check.
// ----------------------------------------------------------------------------
module rau_dp #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rau_pkg::cmd_t        cmd,
  input  logic [1:0]           op_i,
  input  logic [31:0]          an_i,
  input  logic [31:0]          ad_i,
  input  logic [31:0]          bn_i,
  input  logic [31:0]          bd_i,
  output rau_pkg::sts_t        sts,
  output logic [31:0]          res_num,
  output logic [30:0]          res_den,
  output logic [1:0]           res_status
);
  import rau_pkg::*;

  logic [1:0] op_r;
  logic signed [MUL_BITS-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [WIDE_BITS-1:0] p0_r, p1_r, p2_r;
  logic [WIDE_BITS-1:0] nmag_r, dmag_r, x_r, y_r, rem_r, quo_r, dvd_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic nneg_r, dneg_r, zero_r, in_gcd_r;
  logic [1:0] status_r;
  logic [31:0] rnum_r;
  logic [30:0] rden_r;

  function automatic logic signed [MUL_BITS-1:0] sx(input logic [31:0] v);
    logic [WORD_BITS-1:0] w;
    w = v[WORD_BITS-1:0];
    return MUL_BITS'(signed'(w));
  endfunction

  logic signed [MUL_BITS-1:0] ma, mb;
  logic signed [2*MUL_BITS-1:0] mprod, dprod;
  logic [WIDE_BITS-1:0] nu, du, nu_m, du_m;
  logic early, zden;
  assign zden  = (sx(ad_i) == '0) || (sx(bd_i) == '0);
  assign early = zden || (op_t'(op_i) == OP_DIV && sx(bn_i) == '0);

  always_comb begin
    ma = an_r;
    mb = bd_r;
    if (cmd.mul2) begin
      ma = (op_r == OP_DIV) ? ad_r : (op_r == OP_MUL) ? an_r : bn_r;
      mb = (op_r == OP_DIV) ? bn_r : (op_r == OP_MUL) ? bn_r : ad_r;
    end
    mprod = ma * mb;
  end

  assign dprod = ad_r * bd_r;

  always_comb begin
    unique case (op_t'(op_r))
      OP_ADD:  nu = p0_r + p1_r;
      OP_SUB:  nu = p0_r - p1_r;
      OP_MUL:  nu = p1_r;
      default: nu = p0_r;
    endcase
    du = (op_r == OP_DIV) ? p1_r : p2_r;
    nu_m = (nu[WIDE_BITS-1] && nu != {1'b1, {(WIDE_BITS-1){1'b0}}}) ? -nu : nu;
    du_m = (du[WIDE_BITS-1] && du != {1'b1, {(WIDE_BITS-1){1'b0}}}) ? -du : du;
  end

  // one restoring remainder/quotient bit per cycle
  logic [WIDE_BITS:0] trial;
  logic [WIDE_BITS-1:0] rsh;
  logic [WIDE_BITS-1:0] divisor;
  assign divisor = in_gcd_r ? y_r : x_r;
  assign rsh   = {rem_r[WIDE_BITS-2:0], dvd_r[WIDE_BITS-1]};
  assign trial = {rem_r[WIDE_BITS-1], rsh} - {1'b0, divisor};
  logic fit;
  assign fit = !trial[WIDE_BITS];
  logic last;
  assign last = (cnt_r == CNT_BITS'(WIDE_BITS - 1));
  logic [WIDE_BITS-1:0] rem_nxt, dvd_nxt;
  assign rem_nxt = fit ? trial[WIDE_BITS-1:0] : rsh;
  assign dvd_nxt = {dvd_r[WIDE_BITS-2:0], fit};

  localparam logic [WIDE_BITS-1:0] LIM = WIDE_BITS'(1) << (WORD_BITS - 1);
  logic neg;
  assign neg = nneg_r ^ dneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) in_gcd_r <= 1'b0;
    else if (cmd.gcd_init) in_gcd_r <= 1'b1;
    else if (cmd.divn_init || cmd.divd_init) in_gcd_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_i;
      an_r <= sx(an_i); ad_r <= sx(ad_i); bn_r <= sx(bn_i); bd_r <= sx(bd_i);
      status_r <= zden ? ST_ZERODEN : early ? ST_DIVZERO : ST_OK;
      rnum_r <= '0; rden_r <= '0;
    end
    if (cmd.mul1) begin
      p0_r <= mprod[WIDE_BITS-1:0];
      p2_r <= dprod[WIDE_BITS-1:0];
    end
    if (cmd.mul2) p1_r <= mprod[WIDE_BITS-1:0];
    if (cmd.comb) begin
      nmag_r <= nu_m; dmag_r <= du_m;
      nneg_r <= nu[WIDE_BITS-1] && nu != {1'b1, {(WIDE_BITS-1){1'b0}}};
      dneg_r <= du[WIDE_BITS-1] && du != {1'b1, {(WIDE_BITS-1){1'b0}}};
      zero_r <= (nu == '0);
    end
    if (cmd.gcd_init) begin
      x_r <= nmag_r; y_r <= dmag_r; dvd_r <= nmag_r;
      rem_r <= '0; cnt_r <= '0;
    end else if (cmd.divn_init) begin
      dvd_r <= nmag_r; rem_r <= '0; cnt_r <= '0;
    end else if (cmd.divd_init) begin
      dvd_r <= dmag_r; rem_r <= '0; cnt_r <= '0;
      nmag_r <= quo_r;
    end else if (cmd.step) begin
      if (in_gcd_r && y_r == '0) begin
        cnt_r <= '0;
      end else if (last) begin
        cnt_r <= '0;
        if (in_gcd_r) begin
          x_r <= y_r;
          y_r <= rem_nxt;
          dvd_r <= y_r;
          rem_r <= '0;
        end else begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_nxt;
          quo_r <= dvd_nxt;
        end
      end else begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_nxt;
        cnt_r <= cnt_r + CNT_BITS'(1);
      end
    end
    // nmag_r holds the reduced numerator, quo_r the reduced denominator
    if (cmd.fin) begin
      if (zero_r) begin
        rnum_r <= '0; rden_r <= 31'd1;
      end else if ((neg ? nmag_r > LIM : nmag_r > LIM - 64'd1) ||
                   quo_r > LIM - 64'd1) begin
        status_r <= ST_OVF;
      end else begin
        rnum_r <= neg ? 32'(-nmag_r) : nmag_r[31:0];
        rden_r <= quo_r[30:0];
      end
    end
  end

  assign sts.early_err = (status_r != ST_OK);
  assign sts.num_zero  = zero_r;
  assign sts.gcd_done  = in_gcd_r && (y_r == '0);
  assign sts.div_done  = !in_gcd_r && last;
  assign res_num    = rnum_r;
  assign res_den    = rden_r;
  assign res_status = status_r;
endmodule

FILE: hw/rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add/sub/mul/div of two fractions, reduced by gcd, sign on numerator.
// ----------------------------------------------------------------------------
// One word at a time: in_ready is high only while idle, and the next word is
// taken at the earliest in the cycle after the result word leaves. A word with
// a zero denominator or a division by zero goes from S_CHECK straight to
// S_OUT; one with a zero numerator skips the Euclid loop and both divisions;
// any other runs k Euclid remainder steps (each a bit-serial 64-bit
// remainder, k up to about 92) and then the two reducing divisions. The
// result register holds until taken.
module rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [31:0] rn;
  logic [30:0] rd;
  logic [1:0]  rs;

  rau_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_ready(out_ch.ready),
    .sts, .cmd
  );

  rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .rst_n, .cmd,
    .op_i(in_ch.op), .an_i(in_ch.a_num), .ad_i(in_ch.a_den),
    .bn_i(in_ch.b_num), .bd_i(in_ch.b_den),
    .sts, .res_num(rn), .res_den(rd), .res_status(rs)
  );

  assign out_ch.valid   = cmd.out_valid;
  assign out_ch.res_num = rn;
  assign out_ch.res_den = rd;
  assign out_ch.status  = rs;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_OK) |-> out_ch.res_den != '0)
    else $error("ok result with zero denominator");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> out_ch.res_den == '0)
    else $error("error result with nonzero denominator");
endmodule

FILE: tb/rational_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Drives operand words through the unit with bursty input and a stalling
// output. Each result word is compared with a fraction predicted in the
// bench from exact 64-bit cross products and Euclid reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam int WDOG_LIMIT = 40000;
  localparam int LONG_HOLD  = 4000;
  localparam int N_RANDOM   = 1630;

  typedef struct {
    op_t                op;
    logic signed [31:0] an, ad, bn, bd;
    bit                 drain;
  } operand_word_t;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    status_t            st;
  } fraction_t;

  logic clk;
  logic rst_n;
  rau_in_if  in_ch();
  rau_out_if out_ch();

  rational_arithmetic_unit #(.WORD_BITS(32)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  operand_word_t pending_q[$];
  fraction_t     expected_q[$];
  operand_word_t cur;
  int errors = 0;
  int burst_left = 0, gap_left = 0;
  int results_seen = 0, hold_left = 0;
  bit hold_done = 0;
  int idle_cycles = 0;

  function automatic bit [63:0] split_mag(bit [63:0] u, output bit neg);
    if (u[63] && u != 64'h8000_0000_0000_0000) begin
      neg = 1'b1;
      return -u;
    end
    neg = 1'b0;
    return u;
  endfunction

  function automatic fraction_t reduce_fraction(operand_word_t w);
    fraction_t f;
    longint sa, sad, sb, sbd;
    bit [63:0] nu, du, nm, dm, x, y, r, lim;
    bit nn, dn, ng;
    f.num = '0;
    f.den = '0;
    sa = w.an; sad = w.ad; sb = w.bn; sbd = w.bd;
    if (sad == 0 || sbd == 0) begin
      f.st = ST_ZERODEN;
      return f;
    end
    if (w.op == OP_DIV && sb == 0) begin
      f.st = ST_DIVZERO;
      return f;
    end
    case (w.op)
      OP_ADD: begin
        nu = 64'(sa * sbd) + 64'(sb * sad);
        du = 64'(sad * sbd);
      end
      OP_SUB: begin
        nu = 64'(sa * sbd) - 64'(sb * sad);
        du = 64'(sad * sbd);
      end
      OP_MUL: begin
        nu = 64'(sa * sb);
        du = 64'(sad * sbd);
      end
      default: begin
        nu = 64'(sa * sbd);
        du = 64'(sad * sb);
      end
    endcase
    nm = split_mag(nu, nn);
    dm = split_mag(du, dn);
    if (nm == 0) begin
      f.den = 31'd1;
      f.st = ST_OK;
      return f;
    end
    x = nm;
    y = dm;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    nm = nm / x;
    dm = dm / x;
    ng = nn ^ dn;
    lim = 64'h1 << 31;
    if ((ng ? nm > lim : nm > lim - 1) || dm > lim - 1) begin
      f.st = ST_OVF;
      return f;
    end
    f.num = ng ? 32'(-nm) : 32'(nm);
    f.den = 31'(dm);
    f.st = ST_OK;
    return f;
  endfunction

  function automatic logic signed [31:0] rand_operand(bit nonzero);
    logic signed [31:0] v;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55)      v = $signed($urandom_range(0, 40)) - 20;
    else if (k < 75) v = $signed($urandom_range(0, 65535)) - 32768;
    else if (k < 92) v = $urandom;
    else case ($urandom_range(0, 3))
      0: v = 32'sh7fff_ffff;
      1: v = 32'sh8000_0000;
      2: v = 1;
      default: v = -1;
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  task automatic add_word(op_t op, int an, int ad, int bn, int bd, bit drain = 0);
    operand_word_t w;
    w.op = op; w.an = an; w.ad = ad; w.bn = bn; w.bd = bd; w.drain = drain;
    pending_q.push_back(w);
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      in_ch.op <= OP_ADD;
      in_ch.a_num <= 0; in_ch.a_den <= 0; in_ch.b_num <= 0; in_ch.b_den <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_q.push_back(reduce_fraction(cur));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 0;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && (expected_q.size() > 0 || in_ch.valid))) begin
          cur = pending_q.pop_front();
          in_ch.valid <= 1;
          in_ch.op <= cur.op;
          in_ch.a_num <= cur.an; in_ch.a_den <= cur.ad;
          in_ch.b_num <= cur.bn; in_ch.b_den <= cur.bd;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    fraction_t e;
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %0d/%0d st %0d", $time,
                   out_ch.res_num, out_ch.res_den, out_ch.status);
        end else begin
          e = expected_q.pop_front();
          if (out_ch.res_num !== e.num || out_ch.res_den !== e.den ||
              out_ch.status !== e.st) begin
            errors++;
            $display("%0t: expected %0d/%0d st %0d, got %0d/%0d st %0d", $time,
                     e.num, e.den, e.st, out_ch.res_num, out_ch.res_den, out_ch.status);
          end
        end
      end
      if (!hold_done && results_seen == 300) begin
        hold_done = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 0;
      end else if ((results_seen / 100) % 2 == 0) begin
        out_ch.ready <= 1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    operand_word_t w;
    int k;
    add_word(OP_ADD, 1, 2, 1, 3);
    add_word(OP_SUB, 1, 2, 1, 2);
    add_word(OP_MUL, -3, 4, 8, -9);
    add_word(OP_DIV, 5, 7, -10, 21);
    add_word(OP_ADD, 1, 0, 1, 1);
    add_word(OP_DIV, 1, 1, 1, 0);
    add_word(OP_DIV, 3, 4, 0, 5);
    add_word(OP_MUL, 0, 5, 7, -3);
    add_word(OP_ADD, 32'h7fff_ffff, 1, 1, 1);
    add_word(OP_SUB, 32'h8000_0000, 1, 1, 1);
    add_word(OP_MUL, 32'h8000_0000, 1, 1, 1);
    add_word(OP_MUL, 32'h8000_0000, 1, -1, 1);
    add_word(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_word(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_word(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    add_word(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_word(OP_DIV, 1, 32'h7fff_ffff, 1, 32'h7fff_ffff);
    add_word(OP_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe);
    add_word(OP_SUB, 5, -3, 5, -3);
    add_word(OP_DIV, -1, 32'h8000_0000, 1, 1);
    for (k = 0; k < N_RANDOM; k++) begin
      w.op = op_t'($urandom_range(0, 3));
      w.drain = (k == 900);
      if ($urandom_range(0, 9) == 0) begin
        w.an = $urandom; w.ad = $urandom; w.bn = $urandom; w.bd = $urandom;
        if ($urandom_range(0, 1)) w.ad = 0;
        else w.bn = 0;
      end else begin
        w.an = rand_operand(0); w.ad = rand_operand(1);
        w.bn = rand_operand(0); w.bd = rand_operand(1);
      end
      pending_q.push_back(w);
    end
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    while (pending_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_if.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rau_dp.sv
hw/rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_tb.sv
